### src/kway_merge_min_heap_assert.svh
// ----------------------------------------------------------------------------
// kway_merge_min_heap assertion macros
// Property wrappers for the merge block checker.
// ----------------------------------------------------------------------------
`ifndef KWAY_MERGE_MIN_HEAP_ASSERT_SVH
`define KWAY_MERGE_MIN_HEAP_ASSERT_SVH

// same-cycle implication, reset masks the check
`define KWM_ASSERT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define KWM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Types, constants and the heap ordering function for the k-way merge block.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int MAX_RUNS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int RUN_W      = $clog2(MAX_RUNS);
    localparam int CNT_W      = $clog2(MAX_RUNS + 1);
    localparam int NODE_W     = CNT_W + 1;
    localparam int FIELD_W    = VALUE_BITS + RUN_W;
    localparam int TDATA_W    = ((FIELD_W + 7) / 8) * 8;
    localparam int PAD_W      = TDATA_W - FIELD_W;
    localparam int TUSER_W    = 2;

    // s_tuser / m_tuser bit positions
    localparam int IN_CMD_BIT    = 0;
    localparam int IN_EMPTY_BIT  = 1;
    localparam int OUT_VALID_BIT = 0;
    localparam int OUT_DONE_BIT  = 1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD_RD,
        ST_BUILD_CUR,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_MIN,
        OUT_ALL_DONE
    } out_kind_t;

    typedef struct packed {
        logic                         dead;
        logic signed [VALUE_BITS-1:0] val;
        logic [RUN_W-1:0]             run;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic             load_wr;
        logic [RUN_W-1:0] load_addr;
        logic             next_set;
        logic             build_rd;
        logic             build_cur;
        logic [RUN_W-1:0] build_idx;
        logic             sift_rd;
        logic             sift_cmp;
        logic [CNT_W-1:0] n;
        logic             out_load;
        out_kind_t        out_kind;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic l_ok;
        logic moved;
    } dp_stat_t;

    // heap order: live before exhausted, then signed value, then run index
    function automatic logic precedes(entry_t a, entry_t b);
        logic res;
        if (a.dead != b.dead) begin
            res = !a.dead;
        end else if (!a.dead && (a.val != b.val)) begin
            res = ($signed(a.val) < $signed(b.val));
        end else begin
            res = (a.run < b.run);
        end
        return res;
    endfunction

endpackage

### src/kwm_ctrl.sv
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer for load, heap build and sift-down; owns counts and output valid.
// ----------------------------------------------------------------------------
module kwm_ctrl
    import kwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_command,
    input  logic             in_empty,
    output logic             out_valid,
    input  logic             out_ready,
    output dp_cmd_t          cmd,
    input  dp_stat_t         stat
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] num_runs_reg, num_runs_next;
    logic [CNT_W-1:0] loaded_reg, loaded_next;
    logic [CNT_W-1:0] exh_reg, exh_next;
    logic [RUN_W-1:0] build_idx_reg, build_idx_next;
    logic             building_reg, building_next;
    logic             rep_reg, rep_next;
    logic             out_valid_reg, out_valid_next;

    logic [CNT_W-1:0] n_eff;
    logic             accept;
    logic             fresh;
    logic [CNT_W-1:0] base_cnt;
    logic [CNT_W-1:0] load_cnt;
    logic [CNT_W-1:0] exh_base;
    logic             last_load;
    logic             built;
    logic             next_live;
    logic             more_build;
    logic             out_free;

    assign n_eff = (num_runs_reg == '0) ? CNT_W'(1) :
                   (num_runs_reg > CNT_W'(MAX_RUNS)) ? CNT_W'(MAX_RUNS) : num_runs_reg;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign fresh      = (loaded_reg >= n_eff);
    assign base_cnt   = fresh ? '0 : loaded_reg;
    assign load_cnt   = base_cnt + CNT_W'(1);
    assign exh_base   = fresh ? '0 : exh_reg;
    assign last_load  = (load_cnt == n_eff);
    assign built      = (loaded_reg >= n_eff);
    assign next_live  = built && (exh_reg < n_eff);
    assign more_build = building_reg && (build_idx_reg != '0);
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_command == CMD_LOAD) begin
                        state_next = (last_load && (n_eff > CNT_W'(1))) ? ST_BUILD_RD : ST_DONE;
                    end else begin
                        state_next = next_live ? ST_SIFT_RD : ST_DONE;
                    end
                end
            end
            ST_BUILD_RD:  state_next = ST_BUILD_CUR;
            ST_BUILD_CUR: state_next = ST_SIFT_RD;
            ST_SIFT_RD: begin
                if (stat.l_ok) begin
                    state_next = ST_SIFT_CMP;
                end else begin
                    state_next = more_build ? ST_BUILD_RD : ST_DONE;
                end
            end
            ST_SIFT_CMP: begin
                if (stat.moved) begin
                    state_next = ST_SIFT_RD;
                end else begin
                    state_next = more_build ? ST_BUILD_RD : ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd           = '0;
        cmd.n         = n_eff;
        cmd.load_addr = base_cnt[RUN_W-1:0];
        cmd.build_idx = build_idx_reg;
        cmd.out_kind  = OUT_ZERO;
        if (rep_reg) begin
            cmd.out_kind = (exh_reg >= n_eff) ? OUT_ALL_DONE : OUT_MIN;
        end
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_wr  = accept && (in_command == CMD_LOAD);
                cmd.next_set = accept && (in_command == CMD_NEXT) && next_live;
            end
            ST_BUILD_RD:  cmd.build_rd  = 1'b1;
            ST_BUILD_CUR: cmd.build_cur = 1'b1;
            ST_SIFT_RD:   cmd.sift_rd   = 1'b1;
            ST_SIFT_CMP:  cmd.sift_cmp  = 1'b1;
            ST_DONE:      cmd.out_load  = out_free;
            default: ;
        endcase
    end

    // counters and flags
    always_comb begin
        num_runs_next  = num_runs_reg;
        loaded_next    = loaded_reg;
        exh_next       = exh_reg;
        build_idx_next = build_idx_reg;
        building_next  = building_reg;
        rep_next       = rep_reg;

        if (accept) begin
            if (in_command == CMD_LOAD) begin
                loaded_next    = load_cnt;
                exh_next       = exh_base + CNT_W'(in_empty);
                rep_next       = last_load;
                building_next  = last_load;
                build_idx_next = RUN_W'((n_eff >> 1) - CNT_W'(1));
            end else begin
                rep_next      = built;
                building_next = 1'b0;
                if (next_live) begin
                    exh_next = exh_reg + CNT_W'(in_empty);
                end
            end
        end

        // a finished sift during the build moves to the next lower node
        if (((state_reg == ST_SIFT_RD) && !stat.l_ok) ||
            ((state_reg == ST_SIFT_CMP) && !stat.moved)) begin
            if (more_build) begin
                build_idx_next = build_idx_reg - RUN_W'(1);
            end else begin
                building_next = 1'b0;
            end
        end

        // register write aborts any merge in progress
        if (cfg_we) begin
            num_runs_next = cfg_wdata;
            loaded_next   = '0;
            exh_next      = '0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            num_runs_reg  <= CNT_W'(MAX_RUNS);
            loaded_reg    <= '0;
            exh_reg       <= '0;
            build_idx_reg <= '0;
            building_reg  <= 1'b0;
            rep_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            num_runs_reg  <= num_runs_next;
            loaded_reg    <= loaded_next;
            exh_reg       <= exh_next;
            build_idx_reg <= build_idx_next;
            building_reg  <= building_next;
            rep_reg       <= rep_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/kwm_datapath.sv
// ----------------------------------------------------------------------------
// kwm_datapath
// Heap memory, sifting entry, child compare and output payload register.
// ----------------------------------------------------------------------------
module kwm_datapath
    import kwm_pkg::*;
(
    input  logic                  clk,
    input  dp_cmd_t               cmd,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic                  in_empty,
    input  logic [RUN_W-1:0]      in_run,
    output dp_stat_t              stat,
    output logic [TDATA_W-1:0]    out_tdata,
    output logic [TUSER_W-1:0]    out_tuser
);

    entry_t heap_mem [MAX_RUNS];

    entry_t             cur_reg, cur_next;
    logic [RUN_W-1:0]   pos_reg, pos_next;
    entry_t             rd_l_reg;
    entry_t             rd_r_reg;
    logic               r_ok_reg;
    entry_t             root_reg;
    logic [TDATA_W-1:0] tdata_reg;
    logic [TUSER_W-1:0] tuser_reg;

    entry_t             load_entry;
    entry_t             next_entry;
    logic [NODE_W-1:0]  l_node;
    logic [NODE_W-1:0]  r_node;
    logic               l_ok;
    logic               r_ok;
    logic               lc, rc, rl;
    logic               take_r;
    logic               moved;
    entry_t             best;
    logic [RUN_W-1:0]   child_addr;
    logic               we;
    logic [RUN_W-1:0]   waddr;
    entry_t             wdata;

    assign load_entry.dead = in_empty;
    assign load_entry.val  = in_empty ? '0 : in_value;
    assign load_entry.run  = in_run;

    // replacement root keeps the run tag of the reported minimum
    assign next_entry.dead = in_empty;
    assign next_entry.val  = in_empty ? '0 : in_value;
    assign next_entry.run  = root_reg.run;

    assign l_node = {1'b0, pos_reg, 1'b1};
    assign r_node = l_node + NODE_W'(1);
    assign l_ok   = (l_node < {1'b0, cmd.n});
    assign r_ok   = (r_node < {1'b0, cmd.n});

    // three compares side by side; ties keep the earlier candidate
    assign lc     = precedes(rd_l_reg, cur_reg);
    assign rc     = precedes(rd_r_reg, cur_reg);
    assign rl     = precedes(rd_r_reg, rd_l_reg);
    assign take_r = lc ? (r_ok_reg && rl) : (r_ok_reg && rc);
    assign moved  = lc || (r_ok_reg && rc);
    assign best   = take_r ? rd_r_reg : rd_l_reg;
    assign child_addr = take_r ? r_node[RUN_W-1:0] : l_node[RUN_W-1:0];

    assign stat.l_ok  = l_ok;
    assign stat.moved = moved;

    // single write port
    always_comb begin
        we    = 1'b0;
        waddr = pos_reg;
        wdata = cur_reg;
        if (cmd.load_wr) begin
            we    = 1'b1;
            waddr = cmd.load_addr;
            wdata = load_entry;
        end else if (cmd.sift_rd && !l_ok) begin
            we = 1'b1;
        end else if (cmd.sift_cmp) begin
            we    = 1'b1;
            wdata = moved ? best : cur_reg;
        end
    end

    always_comb begin
        cur_next = cur_reg;
        pos_next = pos_reg;
        if (cmd.next_set) begin
            cur_next = next_entry;
            pos_next = '0;
        end else if (cmd.build_cur) begin
            cur_next = rd_l_reg;
            pos_next = cmd.build_idx;
        end else if (cmd.sift_cmp && moved) begin
            pos_next = child_addr;
        end
    end

    always_ff @(posedge clk) begin
        if (we) begin
            heap_mem[waddr] <= wdata;
        end
        if (cmd.build_rd) begin
            rd_l_reg <= heap_mem[cmd.build_idx];
        end else if (cmd.sift_rd) begin
            rd_l_reg <= heap_mem[l_node[RUN_W-1:0]];
        end
        if (cmd.sift_rd) begin
            rd_r_reg <= heap_mem[r_node[RUN_W-1:0]];
            r_ok_reg <= r_ok;
        end
    end

    // shadow of slot 0 for reporting
    always_ff @(posedge clk) begin
        if (we && (waddr == '0)) begin
            root_reg <= wdata;
        end
        cur_reg <= cur_next;
        pos_reg <= pos_next;
    end

    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            tdata_reg <= '0;
            tuser_reg <= '0;
            case (cmd.out_kind)
                OUT_MIN: begin
                    tdata_reg <= {{PAD_W{1'b0}}, root_reg.run, root_reg.val};
                    tuser_reg[OUT_VALID_BIT] <= 1'b1;
                end
                OUT_ALL_DONE: begin
                    tuser_reg[OUT_DONE_BIT] <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign out_tdata = tdata_reg;
    assign out_tuser = tuser_reg;

endmodule

### src/kway_merge_min_heap.sv
// ----------------------------------------------------------------------------
// kway_merge_min_heap
// K-way merge of sorted runs through a min-heap, one result word per input.
// ----------------------------------------------------------------------------
// Usage: set num_runs through cfg_we/cfg_wdata while idle (a write restarts
// the merge). Send one load word per run (s_tuser[0] = 0) with its head
// value, or s_tuser[1] = 1 when the run is empty. Every input word yields one
// result word. The last load builds the heap and reports the minimum and its
// run; after that send a next word (s_tuser[0] = 1) carrying the following
// element of the reported run, or the empty flag once it is exhausted.
// m_tuser[1] (all_done) rises when every run is exhausted.
// Flow: one word worked on at a time. A load that is not the last goes
// from idle straight to the done state, which loads the result register. A
// next word sinks the new root d heap levels (at most 4 levels for 16 runs)
// through the sift loop: ST_SIFT_RD reads both children from the heap
// memory, then ST_SIFT_CMP compares and writes back; a node without
// children ends the loop from the read state. The final load adds the
// build: num_runs/2 sifts, each a read, a load, then the sift loop.
// The block is back in idle, ready for the next word, as the result loads.
// Reset clears the counts and state; num_runs returns to 16. The heap memory
// keeps old contents and is only read after loads rewrite it.
// A stalled m_tready holds the result; the next input word is still taken
// and worked on, and its result waits in the last state until the output
// register frees up.
// ----------------------------------------------------------------------------
module kway_merge_min_heap
    import kwm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration: num_runs
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,
    // input words
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,  // [31:0] value, [35:32] run_index, pad
    input  logic [TUSER_W-1:0] s_tuser,  // [0] command, [1] run_empty
    // result words
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,  // [31:0] min_value, [35:32] min_run, pad
    output logic [TUSER_W-1:0] m_tuser   // [0] min_valid, [1] all_done
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller: FSM, run/exhausted counts, build index, output valid
    kwm_ctrl u_ctrl (
        .clk        (aclk),
        .rst_n      (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tuser[IN_CMD_BIT]),
        .in_empty   (s_tuser[IN_EMPTY_BIT]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .cmd        (cmd),
        .stat       (stat)
    );

    // datapath: heap memory, sifting entry, compare, result payload
    kwm_datapath u_datapath (
        .clk       (aclk),
        .cmd       (cmd),
        .in_value  (s_tdata[VALUE_BITS-1:0]),
        .in_empty  (s_tuser[IN_EMPTY_BIT]),
        .in_run    (s_tdata[VALUE_BITS +: RUN_W]),
        .stat      (stat),
        .out_tdata (m_tdata),
        .out_tuser (m_tuser)
    );

endmodule

### src/kwm_checker.sv
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level assertions for the k-way merge block, bound to the top level.
// ----------------------------------------------------------------------------
`include "kway_merge_min_heap_assert.svh"

module kwm_checker
    import kwm_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [TUSER_W-1:0] m_tuser
);

    // held result word stays put
    `KWM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // one word in flight: no accept right after an accept
    `KWM_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while previous word still in work")

    // a minimum and the done flag never come together
    `KWM_ASSERT(a_flags_exclusive, aclk, aresetn, m_tvalid, !(m_tuser[OUT_VALID_BIT] && m_tuser[OUT_DONE_BIT]), "min_valid and all_done both set")

    // no minimum reported means empty payload
    `KWM_ASSERT(a_zero_payload, aclk, aresetn, m_tvalid && !m_tuser[OUT_VALID_BIT], m_tdata == '0, "payload not zero without min_valid")

endmodule

bind kway_merge_min_heap kwm_checker u_kwm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
